### sv/wcst_pkg.sv
// ----------------------------------------------------------------------------
// wcst_pkg
// Shared types, widths and codes of the client station table.
// ----------------------------------------------------------------------------
package wcst_pkg;

	localparam int MAC_W         = 48;
	localparam int SLOT_W        = 4;
	localparam int CLI_IDX_W     = 5;
	localparam int CNT_OUT_W     = 5;
	localparam int SIG_W         = 8;
	localparam int TICK_W        = 32;
	localparam int CFG_W         = 5;
	localparam int AP_SLOTS_DEF  = 16;
	localparam int CLIENTS_DEF   = 20;

	localparam logic [MAC_W-1:0] BCAST_MAC = '1;

	localparam logic       KIND_LOAD  = 1'b0;
	localparam logic       KIND_FRAME = 1'b1;
	localparam logic [1:0] FT_MGMT    = 2'd0;
	localparam logic [1:0] FT_CTRL    = 2'd1;
	localparam logic [1:0] FT_DATA    = 2'd2;
	localparam logic [1:0] FT_OTHER   = 2'd3;

	typedef enum logic [2:0] {
		ST_LOADED       = 3'd0,
		ST_TYPE_IGNORED = 3'd1,
		ST_NO_AP        = 3'd2,
		ST_NO_DIRECTION = 3'd3,
		ST_BROADCAST    = 3'd4,
		ST_UPDATED      = 3'd5,
		ST_ADDED        = 3'd6,
		ST_FULL         = 3'd7
	} status_t;

	typedef struct packed {
		logic                     kind;
		logic [SLOT_W-1:0]        ap_slot;
		logic [MAC_W-1:0]         load_bssid;
		logic [1:0]               frame_type;
		logic                     to_ds;
		logic                     from_ds;
		logic [MAC_W-1:0]         addr1;
		logic [MAC_W-1:0]         addr2;
		logic [MAC_W-1:0]         addr3;
		logic signed [SIG_W-1:0]  signal_dbm;
		logic [TICK_W-1:0]        now_ticks;
	} item_t;

	typedef struct packed {
		status_t                  status;
		logic [SLOT_W-1:0]        ap_index;
		logic [CLI_IDX_W-1:0]     client_index;
		logic [MAC_W-1:0]         client_address;
		logic [CNT_OUT_W-1:0]     clients_now;
	} result_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

### sv/wcst_if.sv
// ----------------------------------------------------------------------------
// wcst_item_if / wcst_result_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface wcst_item_if;
	import wcst_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface wcst_result_if;
	import wcst_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### sv/wcst_ram.sv
// ----------------------------------------------------------------------------
// wcst_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wcst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/wcst_scan.sv
// ----------------------------------------------------------------------------
// wcst_scan
// Shared address search unit: walks a RAM from entry 0 below a limit, one
// read per cycle, and compares each returned word with a key.
// ----------------------------------------------------------------------------
module wcst_scan #(
	parameter int IDX_W = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [IDX_W:0]            limit,
	input  logic [wcst_pkg::MAC_W-1:0] key,
	input  logic [wcst_pkg::MAC_W-1:0] rd_data,
	output logic [IDX_W-1:0]          rd_idx,
	output logic [IDX_W-1:0]          hit_idx,
	output wcst_pkg::scan_stat_t      stat
);
	import wcst_pkg::*;

	logic             run_q;
	logic [IDX_W:0]   idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             issue;
	logic             match;
	logic             miss;

	assign issue   = run_q && (idx_q < limit);
	assign match   = vld_s1 && (rd_data == key);
	assign miss    = run_q && !vld_s1 && !issue;
	assign rd_idx  = idx_q[IDX_W-1:0];
	assign hit_idx = idx_s1;

	always_comb begin
		stat.done = match || miss;
		stat.hit  = match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (start) begin
			run_q  <= 1'b1;
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (run_q) begin
			if (match || miss) begin
				run_q  <= 1'b0;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && !match && !miss) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
	end

endmodule

### sv/wlan_client_station_table.sv
// ----------------------------------------------------------------------------
// wlan_client_station_table
// Access point BSSID table with a learned client list per access point.
// ----------------------------------------------------------------------------
// Input items arrive on the items channel (valid/ready). A load item writes
// one BSSID slot and clears that slot's client count; a frame item is matched
// by address 3 against the slots below the search depth and then looks up,
// refreshes or appends its client station. Every item yields one result item
// on the results channel. The search depth is written through cfg_we/cfg_wdata
// and the user must keep to writing it only while idle; the block does not enforce it.
// A load or ignored item goes from IDLE through RESULT to the output register;
// a frame item also passes AP_SCAN and, for a client lookup, CL_PREP and
// CL_SCAN. Both searches share one compare unit that reads one RAM word per
// cycle, and items are taken one at a time: ready is high only while no item
// is in progress.
// A finished result sits in an output register, so the next item is accepted
// while the receiver stalls; a second result then waits until the first is
// taken. Reset clears all client counts and the search depth; BSSID and
// client RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module wlan_client_station_table #(
	parameter int AP_SLOTS       = wcst_pkg::AP_SLOTS_DEF,
	parameter int CLIENTS_PER_AP = wcst_pkg::CLIENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [wcst_pkg::CFG_W-1:0] cfg_wdata,
	wcst_item_if.sink                  items,
	wcst_result_if.source              results
);
	import wcst_pkg::*;

	localparam int AP_W  = (AP_SLOTS > 1) ? $clog2(AP_SLOTS) : 1;
	localparam int CL_W  = (CLIENTS_PER_AP > 1) ? $clog2(CLIENTS_PER_AP) : 1;
	localparam int IDX_W = (AP_W > CL_W) ? AP_W : CL_W;
	localparam int SC_W  = IDX_W + 1;
	localparam int CNT_W = $clog2(CLIENTS_PER_AP + 1);
	localparam int CL_DEPTH = AP_SLOTS * CLIENTS_PER_AP;
	localparam int CL_AW = (CL_DEPTH > 1) ? $clog2(CL_DEPTH) : 1;
	localparam int CL_DW = TICK_W + SIG_W + MAC_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AP_SCAN,
		S_CL_PREP,
		S_CL_SCAN,
		S_RESULT
	} state_t;

	state_t             state_q;
	item_t              item_q;
	result_t            res_q;
	result_t            out_q;
	logic               out_vld_q;
	logic [CFG_W-1:0]   ap_span_q;
	logic [CNT_W-1:0]   ap_cnt_q [AP_SLOTS];
	logic [AP_W-1:0]    ap_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MAC_W-1:0]   mac_q;
	logic [CL_AW-1:0]   base_q;

	logic               accept;
	logic               out_load;
	result_t            res_nx;
	logic               cl_phase;
	logic [SC_W-1:0]    ap_lim;
	logic [SC_W-1:0]    sc_limit;
	logic [MAC_W-1:0]   sc_key;
	logic [MAC_W-1:0]   sc_data;
	logic               sc_start;
	logic [IDX_W-1:0]   sc_rd_idx;
	logic [IDX_W-1:0]   sc_hit_idx;
	scan_stat_t         sc_stat;

	logic               ap_we;
	logic [MAC_W-1:0]   ap_rdata;
	logic               cl_we;
	logic               cl_add;
	logic               cl_room;
	logic [CL_AW-1:0]   cl_waddr;
	logic [CL_AW-1:0]   cl_raddr;
	logic [CL_DW-1:0]   cl_wdata;
	logic [CL_DW-1:0]   cl_rdata;
	logic               load_ok;
	logic               type_ok;
	logic               dir_ok;
	logic [MAC_W-1:0]   sel_mac;
	logic [CNT_W-1:0]   cnt_rd;

	assign items.ready   = (state_q == S_IDLE);
	assign accept        = items.valid && items.ready;
	assign results.valid = out_vld_q;
	assign results.data  = out_q;
	assign out_load      = (state_q == S_RESULT) && (!out_vld_q || results.ready);

	assign load_ok = (32'(items.data.ap_slot) < AP_SLOTS);
	assign type_ok = (items.data.frame_type == FT_MGMT) || (items.data.frame_type == FT_DATA);
	assign ap_we   = accept && (items.data.kind == KIND_LOAD) && load_ok;

	assign cl_phase = (state_q == S_CL_SCAN);
	assign ap_lim   = (32'(ap_span_q) < AP_SLOTS) ? SC_W'(ap_span_q) : SC_W'(AP_SLOTS);
	assign sc_limit = cl_phase ? SC_W'(cnt_q) : ap_lim;
	assign sc_key   = cl_phase ? mac_q : item_q.addr3;
	assign sc_data  = cl_phase ? cl_rdata[MAC_W-1:0] : ap_rdata;
	assign sc_start = (accept && (items.data.kind == KIND_FRAME) && type_ok)
		|| (state_q == S_CL_PREP);

	assign dir_ok  = item_q.to_ds ^ item_q.from_ds;
	assign sel_mac = item_q.to_ds ? item_q.addr2 : item_q.addr1;
	assign cnt_rd  = ap_cnt_q[AP_W'(sc_hit_idx)];

	assign cl_room  = (32'(cnt_q) < CLIENTS_PER_AP);
	assign cl_we    = cl_phase && sc_stat.done && (sc_stat.hit || cl_room);
	assign cl_add   = cl_phase && sc_stat.done && !sc_stat.hit && cl_room;
	assign cl_waddr = base_q + (sc_stat.hit ? CL_AW'(sc_hit_idx) : CL_AW'(cnt_q));
	assign cl_raddr = base_q + CL_AW'(sc_rd_idx);
	assign cl_wdata = {item_q.now_ticks, item_q.signal_dbm, mac_q};

	always_comb begin
		res_nx = '0;
		unique case (state_q)
			S_IDLE: begin
				if (items.data.kind == KIND_LOAD) begin
					res_nx.status   = ST_LOADED;
					res_nx.ap_index = items.data.ap_slot;
				end else begin
					res_nx.status = ST_TYPE_IGNORED;
				end
			end
			S_AP_SCAN: begin
				if (!sc_stat.hit) begin
					res_nx.status = ST_NO_AP;
				end else begin
					res_nx.ap_index    = SLOT_W'(sc_hit_idx);
					res_nx.clients_now = CNT_OUT_W'(cnt_rd);
					if (!dir_ok) begin
						res_nx.status = ST_NO_DIRECTION;
					end else begin
						res_nx.status         = ST_BROADCAST;
						res_nx.client_address = sel_mac;
					end
				end
			end
			S_CL_SCAN: begin
				res_nx.ap_index       = SLOT_W'(ap_q);
				res_nx.client_address = mac_q;
				res_nx.clients_now    = CNT_OUT_W'(cnt_q);
				if (sc_stat.hit) begin
					res_nx.status       = ST_UPDATED;
					res_nx.client_index = CLI_IDX_W'(sc_hit_idx);
				end else if (cl_room) begin
					res_nx.status       = ST_ADDED;
					res_nx.client_index = CLI_IDX_W'(cnt_q);
					res_nx.clients_now  = CNT_OUT_W'(cnt_q + CNT_W'(1));
				end else begin
					res_nx.status = ST_FULL;
				end
			end
			default: begin
				res_nx = res_q;
			end
		endcase
	end

	wcst_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sc_start),
		.limit   (sc_limit),
		.key     (sc_key),
		.rd_data (sc_data),
		.rd_idx  (sc_rd_idx),
		.hit_idx (sc_hit_idx),
		.stat    (sc_stat)
	);

	wcst_ram #(
		.WIDTH (MAC_W),
		.DEPTH (AP_SLOTS)
	) u_bssid_ram (
		.clk   (clk),
		.we    (ap_we),
		.waddr (AP_W'(items.data.ap_slot)),
		.wdata (items.data.load_bssid),
		.raddr (AP_W'(sc_rd_idx)),
		.rdata (ap_rdata)
	);

	wcst_ram #(
		.WIDTH (CL_DW),
		.DEPTH (CL_DEPTH)
	) u_client_ram (
		.clk   (clk),
		.we    (cl_we),
		.waddr (cl_waddr),
		.wdata (cl_wdata),
		.raddr (cl_raddr),
		.rdata (cl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_span_q <= '0;
		end else if (cfg_we) begin
			ap_span_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AP_SLOTS; k++) begin
				ap_cnt_q[k] <= '0;
			end
		end else begin
			if (ap_we) begin
				ap_cnt_q[AP_W'(items.data.ap_slot)] <= '0;
			end
			if (cl_add) begin
				ap_cnt_q[ap_q] <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			item_q    <= '0;
			res_q     <= '0;
			out_q     <= '0;
			ap_q      <= '0;
			cnt_q     <= '0;
			mac_q     <= '0;
			base_q    <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= items.data;
						res_q  <= res_nx;
						if ((items.data.kind == KIND_LOAD) || !type_ok) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_AP_SCAN;
						end
					end
				end
				S_AP_SCAN: begin
					if (sc_stat.done) begin
						res_q <= res_nx;
						ap_q  <= AP_W'(sc_hit_idx);
						cnt_q <= cnt_rd;
						mac_q <= sel_mac;
						if (!sc_stat.hit || !dir_ok || (sel_mac == BCAST_MAC)) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_CL_PREP;
						end
					end
				end
				S_CL_PREP: begin
					base_q  <= CL_AW'(ap_q * CLIENTS_PER_AP);
					state_q <= S_CL_SCAN;
				end
				S_CL_SCAN: begin
					if (sc_stat.done) begin
						res_q   <= res_nx;
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_load) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sc_stat.done |-> (state_q == S_AP_SCAN || state_q == S_CL_SCAN))
		else $error("search unit finished outside a search phase");

	a_hit_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(sc_stat.done && sc_stat.hit) |-> (32'(sc_hit_idx) < 32'(sc_limit)))
		else $error("search hit beyond the searched range");

	a_client_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cl_we |-> (32'(cl_waddr) < CL_DEPTH))
		else $error("client write outside the client store");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !items.ready)
		else $error("second item accepted while one is in progress");

endmodule

### sim/tb_wlan_client_station_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wlan_client_station_table
// Self-checking bench for the access point client station table.
// ----------------------------------------------------------------------------
// Loads BSSID slots and sends management, data and other frames through the
// item channel while a local copy of the table predicts each result item.
// Results are compared field by field in order. The search depth is changed
// between phases while the block is idle, both sides idle at random, and the
// receiver holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_wlan_client_station_table;
	import wcst_pkg::*;

	class learned_station_table;
		logic [MAC_W-1:0]  bssid_of [AP_SLOTS_DEF];
		int                clients_of [AP_SLOTS_DEF];
		logic [MAC_W-1:0]  sta_mac [AP_SLOTS_DEF][CLIENTS_DEF];
		logic [SIG_W-1:0]  client_sig [AP_SLOTS_DEF][CLIENTS_DEF];
		logic [TICK_W-1:0] client_seen [AP_SLOTS_DEF][CLIENTS_DEF];
		int                search_depth;
		result_t           due_results [$];
		int                errors;
		int                accepted;
		int                checked;
		int                by_status [8];

		function result_t learn(item_t it);
			result_t r;
			int lim;
			int hit;
			int cnt;
			logic [MAC_W-1:0] mac;
			r = '0;
			if (it.kind == KIND_LOAD) begin
				bssid_of[it.ap_slot] = it.load_bssid;
				clients_of[it.ap_slot] = 0;
				r.status = ST_LOADED;
				r.ap_index = it.ap_slot;
				return r;
			end
			if (it.frame_type != FT_MGMT && it.frame_type != FT_DATA) begin
				r.status = ST_TYPE_IGNORED;
				return r;
			end
			lim = search_depth < AP_SLOTS_DEF ? search_depth : AP_SLOTS_DEF;
			hit = -1;
			for (int i = 0; i < lim; i++)
				if (hit < 0 && bssid_of[i] == it.addr3)
					hit = i;
			if (hit < 0) begin
				r.status = ST_NO_AP;
				return r;
			end
			cnt = clients_of[hit];
			r.ap_index = SLOT_W'(hit);
			r.clients_now = CNT_OUT_W'(cnt);
			if (it.to_ds && !it.from_ds)
				mac = it.addr2;
			else if (!it.to_ds && it.from_ds)
				mac = it.addr1;
			else begin
				r.status = ST_NO_DIRECTION;
				return r;
			end
			r.client_address = mac;
			if (mac == BCAST_MAC) begin
				r.status = ST_BROADCAST;
				return r;
			end
			for (int j = 0; j < cnt; j++)
				if (sta_mac[hit][j] == mac) begin
					client_sig[hit][j] = it.signal_dbm;
					client_seen[hit][j] = it.now_ticks;
					r.status = ST_UPDATED;
					r.client_index = CLI_IDX_W'(j);
					return r;
				end
			if (cnt < CLIENTS_DEF) begin
				sta_mac[hit][cnt] = mac;
				client_sig[hit][cnt] = it.signal_dbm;
				client_seen[hit][cnt] = it.now_ticks;
				clients_of[hit] = cnt + 1;
				r.status = ST_ADDED;
				r.client_index = CLI_IDX_W'(cnt);
				r.clients_now = CNT_OUT_W'(cnt + 1);
				return r;
			end
			r.status = ST_FULL;
			return r;
		endfunction

		function void take_item(item_t it);
			accepted++;
			due_results.push_back(learn(it));
		endfunction

		function bit field_differs(string label, logic [MAC_W-1:0] want,
				logic [MAC_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h got %0h", $time, label, want, got);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit bad;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			checked++;
			by_status[want.status]++;
			bad = field_differs("status", MAC_W'(want.status), MAC_W'(got.status));
			bad |= field_differs("ap_index", MAC_W'(want.ap_index), MAC_W'(got.ap_index));
			bad |= field_differs("client_index", MAC_W'(want.client_index),
				MAC_W'(got.client_index));
			bad |= field_differs("client_address", want.client_address,
				got.client_address);
			bad |= field_differs("clients_now", MAC_W'(want.clients_now),
				MAC_W'(got.clients_now));
			if (bad)
				errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	bit steady;
	bit held_once;
	logic [MAC_W-1:0] client_pool [32];
	learned_station_table board = new();

	wcst_item_if   item_ch ();
	wcst_result_if result_ch ();

	wlan_client_station_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (item_ch),
		.results   (result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("wlan_client_station_table regression: fail");
		$finish;
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[MAC_W-1:0];
	endfunction

	function automatic item_t load_item(logic [SLOT_W-1:0] slot, logic [MAC_W-1:0] bss);
		item_t it;
		it.kind = KIND_LOAD;
		it.ap_slot = slot;
		it.load_bssid = bss;
		it.frame_type = 2'($urandom_range(3));
		it.to_ds = 1'($urandom_range(1));
		it.from_ds = 1'($urandom_range(1));
		it.addr1 = rand_mac();
		it.addr2 = rand_mac();
		it.addr3 = rand_mac();
		it.signal_dbm = SIG_W'($urandom_range(255));
		it.now_ticks = $urandom;
		return it;
	endfunction

	function automatic item_t frame_item(logic [1:0] ftype, logic tods, logic fromds,
			logic [MAC_W-1:0] a1, logic [MAC_W-1:0] a2, logic [MAC_W-1:0] a3);
		item_t it;
		it = load_item(SLOT_W'($urandom_range(15)), rand_mac());
		it.kind = KIND_FRAME;
		it.frame_type = ftype;
		it.to_ds = tods;
		it.from_ds = fromds;
		it.addr1 = a1;
		it.addr2 = a2;
		it.addr3 = a3;
		return it;
	endfunction

	function automatic item_t random_item();
		int pick;
		int lim;
		int slot;
		bit up;
		logic [1:0] ftype;
		logic [MAC_W-1:0] bss;
		logic [MAC_W-1:0] client;
		pick = $urandom_range(99);
		lim = board.search_depth < AP_SLOTS_DEF ? board.search_depth : AP_SLOTS_DEF;
		slot = lim > 0 ? $urandom_range(lim - 1) : $urandom_range(AP_SLOTS_DEF - 1);
		bss = board.bssid_of[slot];
		client = $urandom_range(9) == 0 ? rand_mac() : client_pool[$urandom_range(31)];
		up = 1'($urandom_range(1));
		ftype = $urandom_range(1) ? FT_DATA : FT_MGMT;
		if (pick < 5) begin
			if ($urandom_range(3) == 0)
				bss = board.bssid_of[$urandom_range(AP_SLOTS_DEF - 1)];
			else
				bss = rand_mac();
			return load_item(SLOT_W'($urandom_range(15)), bss);
		end
		if (pick < 11)
			return frame_item(2'($urandom_range(3)), 1'($urandom_range(1)),
				1'($urandom_range(1)), rand_mac(), rand_mac(), rand_mac());
		if (pick < 15)
			return frame_item(ftype, up, up, client, client, bss);
		if (pick < 18)
			return frame_item(ftype, up, !up, BCAST_MAC, BCAST_MAC, bss);
		if (pick < 21)
			bss[$urandom_range(MAC_W - 1)] ^= 1'b1;
		if (up)
			return frame_item(ftype, 1'b1, 1'b0, rand_mac(), client, bss);
		return frame_item(ftype, 1'b0, 1'b1, client, rand_mac(), bss);
	endfunction

	task automatic send_item(item_t it);
		while (!steady && $urandom_range(99) < 6) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		board.take_item(it);
		@(negedge clk);
	endtask

	task automatic settle_table();
		item_ch.valid <= 1'b0;
		while (board.due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_search_depth(int value);
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		board.search_depth = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && board.checked >= 400) begin
				held_once = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			result_ch.ready <= steady || $urandom_range(99) >= 6;
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				board.check_result(result_ch.data);
		end
	end

	initial begin
		item_t it;
		logic [MAC_W-1:0] dup_bssid;
		logic [MAC_W-1:0] client_a;
		logic [MAC_W-1:0] bss;
		int settings [7];
		int sizes [7];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		for (int i = 0; i < 32; i++)
			client_pool[i] = rand_mac();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(frame_item(FT_MGMT, 1'b1, 1'b0, rand_mac(), rand_mac(), '0));
		send_item(frame_item(FT_CTRL, 1'b1, 1'b0, rand_mac(), rand_mac(), rand_mac()));
		send_item(frame_item(FT_OTHER, 1'b0, 1'b1, rand_mac(), rand_mac(), rand_mac()));
		dup_bssid = rand_mac();
		for (int s = 0; s < AP_SLOTS_DEF; s++) begin
			bss = rand_mac();
			if (s == 0)
				bss = '0;
			else if (s == AP_SLOTS_DEF - 1)
				bss = BCAST_MAC;
			else if (s == 2 || s == 5)
				bss = dup_bssid;
			send_item(load_item(SLOT_W'(s), bss));
		end
		settle_table();
		write_search_depth(AP_SLOTS_DEF);

		client_a = rand_mac();
		it = frame_item(FT_DATA, 1'b0, 1'b1, client_a, rand_mac(), BCAST_MAC);
		it.signal_dbm = -8'sd128;
		it.now_ticks = '0;
		send_item(it);
		it = frame_item(FT_MGMT, 1'b1, 1'b0, rand_mac(), '0, '0);
		it.signal_dbm = 8'sd127;
		it.now_ticks = '1;
		send_item(it);
		send_item(frame_item(FT_DATA, 1'b0, 1'b1, client_a, rand_mac(), BCAST_MAC));
		send_item(frame_item(FT_MGMT, 1'b1, 1'b0, rand_mac(), client_pool[0], dup_bssid));
		send_item(frame_item(FT_DATA, 1'b1, 1'b1, rand_mac(), rand_mac(), dup_bssid));
		send_item(frame_item(FT_MGMT, 1'b0, 1'b0, rand_mac(), rand_mac(), dup_bssid));
		send_item(frame_item(FT_DATA, 1'b1, 1'b0, rand_mac(), BCAST_MAC, dup_bssid));
		send_item(frame_item(FT_MGMT, 1'b0, 1'b1, rand_mac(), rand_mac(), rand_mac()));
		send_item(load_item(SLOT_W'(AP_SLOTS_DEF - 1), BCAST_MAC));
		send_item(frame_item(FT_DATA, 1'b0, 1'b1, client_a, rand_mac(), BCAST_MAC));
		settle_table();

		settings = '{31, 1, 16, 0, 9, 0, 16};
		settings[5] = $urandom_range(2, 15);
		sizes = '{260, 260, 260, 60, 260, 260, 260};
		for (int p = 0; p < 7; p++) begin
			write_search_depth(settings[p]);
			steady = p == 4;
			repeat (sizes[p]) send_item(random_item());
			settle_table();
		end
		steady = 1'b0;
		repeat (50) @(negedge clk);

		$display("%0d items, %0d results: loaded %0d, ignored %0d, no AP %0d, no direction %0d",
			board.accepted, board.checked, board.by_status[ST_LOADED],
			board.by_status[ST_TYPE_IGNORED], board.by_status[ST_NO_AP],
			board.by_status[ST_NO_DIRECTION]);
		$display("broadcast %0d, updated %0d, added %0d, full %0d; search depth 0/1/9/16/31 and %0d",
			board.by_status[ST_BROADCAST], board.by_status[ST_UPDATED],
			board.by_status[ST_ADDED], board.by_status[ST_FULL], settings[5]);
		if (board.errors == 0 && board.due_results.size() == 0)
			$display("wlan_client_station_table regression: pass");
		else
			$display("wlan_client_station_table regression: fail");
		$finish;
	end

endmodule
